@@ design/tcst_pkg.sv @@
`timescale 1ns / 1ps
package tcst_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int CMP_WIDTH   = 33;
  localparam int ADDR_WIDTH  = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int PADDR_WIDTH = 3;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(60);

  localparam logic REG_CLIENT_ADDR = 1'b0;
  localparam logic REG_TW_LIMIT    = 1'b1;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [3:0] S_CLOSED     = 4'd0;
  localparam logic [3:0] S_SYN_SENT   = 4'd1;
  localparam logic [3:0] S_SYN_RCVD   = 4'd2;
  localparam logic [3:0] S_ESTAB      = 4'd3;
  localparam logic [3:0] S_FIN_WAIT_1 = 4'd4;
  localparam logic [3:0] S_FIN_WAIT_2 = 4'd5;
  localparam logic [3:0] S_TIME_WAIT  = 4'd6;
  localparam logic [3:0] S_CLOSE_WAIT = 4'd7;
  localparam logic [3:0] S_LAST_ACK   = 4'd8;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0]  client_addr;
    logic [LIMIT_WIDTH-1:0] time_wait_limit;
  } cfg_t;

  typedef struct packed {
    logic is_tick;
    logic is_rst;
    logic from_client;
    logic fin;
    logic syn;
    logic ack;
  } op_t;

  typedef struct packed {
    logic [3:0] client_side_state;
    logic [3:0] server_side_state;
    logic       client_changed;
    logic       server_changed;
    logic       clean_up;
  } res_t;

  function automatic logic [3:0] next_client(logic [3:0] cur, op_t op);
    logic [3:0] n;
    n = cur;
    case (cur)
      S_CLOSED:     if (op.syn && !op.ack) n = S_SYN_SENT;
      S_SYN_SENT:   if (op.syn && op.ack) n = S_SYN_RCVD;
      S_SYN_RCVD:   if (op.ack && !op.syn) n = S_ESTAB;
      S_ESTAB:      if (op.fin) n = S_FIN_WAIT_1;
      S_FIN_WAIT_1: begin
        if (op.ack && !op.fin) n = S_FIN_WAIT_2;
        else if (op.fin) n = S_TIME_WAIT;
      end
      S_FIN_WAIT_2: if (op.fin) n = S_TIME_WAIT;
      S_TIME_WAIT:  if (op.ack) n = S_CLOSED;
      default:      n = cur;
    endcase
    if (op.is_rst) n = S_CLOSED;
    return n;
  endfunction

  function automatic logic [3:0] next_server(logic [3:0] cur, op_t op);
    logic [3:0] n;
    n = cur;
    case (cur)
      S_CLOSED:     if (op.syn && !op.ack) n = S_SYN_RCVD;
      S_SYN_RCVD:   if (op.ack && !op.syn) n = S_ESTAB;
      S_ESTAB:      if (op.fin) n = S_CLOSE_WAIT;
      S_CLOSE_WAIT: if (op.fin) n = S_LAST_ACK;
      S_LAST_ACK:   if (op.ack) n = S_CLOSED;
      default:      n = cur;
    endcase
    if (op.is_rst) n = S_CLOSED;
    return n;
  endfunction

endpackage

@@ design/tcst_cfg.sv @@
`timescale 1ns / 1ps
module tcst_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcst_pkg::PADDR_WIDTH-1:0]   paddr,
  input  logic [tcst_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [tcst_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                               pready,
  output tcst_pkg::cfg_t                     cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.client_addr     <= '0;
      cfg.time_wait_limit <= tcst_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      if (reg_sel == tcst_pkg::REG_CLIENT_ADDR) begin
        cfg.client_addr <= pwdata;
      end else begin
        cfg.time_wait_limit <= pwdata[tcst_pkg::LIMIT_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == tcst_pkg::REG_TW_LIMIT) begin
      prdata = tcst_pkg::DATA_WIDTH'(cfg.time_wait_limit);
    end else begin
      prdata = cfg.client_addr;
    end
  end

endmodule

@@ design/tcst_front.sv @@
`timescale 1ns / 1ps
module tcst_front (
  input  logic                              push,
  input  logic                              q_full,
  input  logic                              cmd,
  input  logic [tcst_pkg::ADDR_WIDTH-1:0]   src_addr,
  input  logic [7:0]                        tcp_flags,
  input  tcst_pkg::cfg_t                    cfg,
  output logic                              enq,
  output tcst_pkg::op_t                     op
);

  // flag byte: FIN bit0, SYN bit1, RST bit2, ACK bit4
  assign enq = push && !q_full;

  always_comb begin
    op.is_tick     = (cmd == tcst_pkg::CMD_TICK);
    op.is_rst      = tcp_flags[2];
    op.from_client = (src_addr == cfg.client_addr);
    op.fin         = tcp_flags[0];
    op.syn         = tcp_flags[1];
    op.ack         = tcp_flags[4];
  end

endmodule

@@ design/tcst_opq.sv @@
`timescale 1ns / 1ps
module tcst_opq (
  input  logic          clk,
  input  logic          rst,
  input  logic          enq,
  input  tcst_pkg::op_t enq_op,
  output logic          full,
  input  logic          deq,
  output logic          empty,
  output tcst_pkg::op_t head
);

  tcst_pkg::op_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= enq_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) wr_ptr <= ~wr_ptr;
      if (deq) rd_ptr <= ~rd_ptr;
      count <= count + 2'(enq) - 2'(deq);
    end
  end

endmodule

@@ design/tcst_back.sv @@
`timescale 1ns / 1ps
module tcst_back (
  input  logic           clk,
  input  logic           rst,
  input  tcst_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  tcst_pkg::op_t  op,
  output logic           deq,
  input  logic           pop,
  output logic           empty,
  output tcst_pkg::res_t res
);

  logic [3:0]                     client_fsm;
  logic [3:0]                     server_fsm;
  logic [tcst_pkg::COUNT_WIDTH-1:0] seconds;
  logic [3:0]                     client_next;
  logic [3:0]                     server_next;
  logic [tcst_pkg::COUNT_WIDTH-1:0] seconds_next;
  logic [3:0]                     c1;
  logic [3:0]                     s1;
  logic                           any_change;
  logic                           tw_expired;
  tcst_pkg::res_t                 res_next;

  tcst_pkg::res_t rq [2];
  logic           rq_wr;
  logic           rq_rd;
  logic [1:0]     rq_count;
  logic           rq_pop;

  assign deq    = !q_empty && (rq_count != 2'd2);
  assign empty  = (rq_count == 2'd0);
  assign rq_pop = pop && !empty;
  assign res    = rq[rq_rd];

  always_comb begin
    client_next = client_fsm;
    server_next = server_fsm;
    c1 = tcst_pkg::next_client(client_fsm, op);
    s1 = tcst_pkg::next_server(server_fsm, op);
    if (op.is_tick) begin
      client_next = client_fsm;
      server_next = server_fsm;
    end else if (op.is_rst) begin
      client_next = c1;
      server_next = s1;
    end else if (op.from_client) begin
      client_next = c1;
      // other side follows on the freshly updated client state
      if ((c1 == tcst_pkg::S_SYN_RCVD && op.ack && !op.syn) ||
          (c1 == tcst_pkg::S_ESTAB && op.fin) ||
          (c1 == tcst_pkg::S_TIME_WAIT && op.ack)) begin
        server_next = s1;
      end
    end else begin
      server_next = s1;
      if ((s1 == tcst_pkg::S_SYN_RCVD && op.syn && op.ack) ||
          (s1 == tcst_pkg::S_ESTAB && op.fin) ||
          (s1 == tcst_pkg::S_LAST_ACK && op.ack)) begin
        client_next = tcst_pkg::next_client(client_fsm, op);
      end
    end

    any_change = (client_next != client_fsm) || (server_next != server_fsm);
    if (any_change) begin
      seconds_next = '0;
    end else if (op.is_tick && (seconds != '1)) begin
      seconds_next = seconds + 1'b1;
    end else begin
      seconds_next = seconds;
    end

    tw_expired = (tcst_pkg::CMP_WIDTH'(seconds_next) >=
                  tcst_pkg::CMP_WIDTH'(cfg.time_wait_limit));

    res_next.client_side_state = client_next;
    res_next.server_side_state = server_next;
    res_next.client_changed    = (client_next != client_fsm);
    res_next.server_changed    = (server_next != server_fsm);
    if (client_next == tcst_pkg::S_CLOSED && server_next == tcst_pkg::S_CLOSED) begin
      res_next.clean_up = 1'b1;
    end else if (client_next == tcst_pkg::S_TIME_WAIT ||
                 server_next == tcst_pkg::S_TIME_WAIT) begin
      res_next.clean_up = tw_expired;
    end else begin
      res_next.clean_up = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      client_fsm <= tcst_pkg::S_CLOSED;
      server_fsm <= tcst_pkg::S_CLOSED;
      seconds    <= '0;
    end else if (deq) begin
      client_fsm <= client_next;
      server_fsm <= server_next;
      seconds    <= seconds_next;
    end
  end

  always_ff @(posedge clk) begin
    if (deq) begin
      rq[rq_wr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (deq) rq_wr <= ~rq_wr;
      if (rq_pop) rq_rd <= ~rq_rd;
      rq_count <= rq_count + 2'(deq) - 2'(rq_pop);
    end
  end

endmodule

@@ design/tcp_connection_state_tracker_unit.sv @@
`timescale 1ns / 1ps
// channel   handshake                       payload
// input     push / full                     cmd, src_addr, tcp_flags
// result    empty / pop                     client_side_state, server_side_state,
//                                           client_changed, server_changed, clean_up
// config    psel/penable/pwrite/pready      paddr, pwdata, prdata
//
// One item per cycle sustained while pop keeps up; a result passes through the op
// queue and then the result queue before it reaches the result ports.
// The front classifies into a 2-entry op queue; the back updates state as it dequeues
// each op and writes a 2-entry result queue. Synchronous reset empties both queues and
// restores config defaults. A stalled result side fills the result queue, then the
// op queue, then raises full.
module tcp_connection_state_tracker_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              cmd,
  input  logic [tcst_pkg::ADDR_WIDTH-1:0]   src_addr,
  input  logic [7:0]                        tcp_flags,
  output logic                              empty,
  input  logic                              pop,
  output logic [3:0]                        client_side_state,
  output logic [3:0]                        server_side_state,
  output logic                              client_changed,
  output logic                              server_changed,
  output logic                              clean_up,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcst_pkg::PADDR_WIDTH-1:0]  paddr,
  input  logic [tcst_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [tcst_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                              pready
);

  tcst_pkg::cfg_t cfg;
  tcst_pkg::op_t  enq_op;
  tcst_pkg::op_t  head;
  tcst_pkg::res_t res;
  logic           enq;
  logic           deq;
  logic           q_empty;

  tcst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcst_front u_front (
    .push      (push),
    .q_full    (full),
    .cmd       (cmd),
    .src_addr  (src_addr),
    .tcp_flags (tcp_flags),
    .cfg       (cfg),
    .enq       (enq),
    .op        (enq_op)
  );

  tcst_opq u_opq (
    .clk    (clk),
    .rst    (rst),
    .enq    (enq),
    .enq_op (enq_op),
    .full   (full),
    .deq    (deq),
    .empty  (q_empty),
    .head   (head)
  );

  tcst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .op      (head),
    .deq     (deq),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign client_side_state = res.client_side_state;
  assign server_side_state = res.server_side_state;
  assign client_changed    = res.client_changed;
  assign server_changed    = res.server_changed;
  assign clean_up          = res.clean_up;

endmodule

@@ design/tcst_checker.sv @@
`timescale 1ns / 1ps
module tcst_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [3:0] client_side_state,
  input logic [3:0] server_side_state,
  input logic       client_changed,
  input logic       server_changed,
  input logic       clean_up
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_closed_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && client_side_state == tcst_pkg::S_CLOSED &&
     server_side_state == tcst_pkg::S_CLOSED) |-> clean_up)
    else $error("both sides closed without clean_up");

  a_clean_cause: assert property (@(posedge clk) disable iff (rst)
    (!empty && clean_up) |->
      ((client_side_state == tcst_pkg::S_CLOSED &&
        server_side_state == tcst_pkg::S_CLOSED) ||
       client_side_state == tcst_pkg::S_TIME_WAIT ||
       server_side_state == tcst_pkg::S_TIME_WAIT))
    else $error("clean_up without closed pair or TIME-WAIT side");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (client_side_state <= tcst_pkg::S_LAST_ACK &&
                server_side_state <= tcst_pkg::S_LAST_ACK))
    else $error("state code out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(client_side_state) &&
      $stable(server_side_state) && $stable(client_changed) &&
      $stable(server_changed) && $stable(clean_up)))
    else $error("result changed while stalled");

endmodule

bind tcp_connection_state_tracker_unit tcst_checker u_tcst_checker (
  .clk               (clk),
  .rst               (rst),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .client_side_state (client_side_state),
  .server_side_state (server_side_state),
  .client_changed    (client_changed),
  .server_changed    (server_changed),
  .clean_up          (clean_up)
);
